// ===== hdl/cic_pkg.sv =====
// shared types, constants and helper functions for the cartridge image checksum
`default_nettype none

package cic_pkg;

  localparam int TABLE_WORDS = 64;
  localparam int TABLE_AW    = $clog2(TABLE_WORDS);
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // boot chip variant codes, codes above the last one mean unknown
  localparam logic [2:0] VARIANT_6102 = 3'd0;
  localparam logic [2:0] VARIANT_6103 = 3'd1;
  localparam logic [2:0] VARIANT_6105 = 3'd2;
  localparam logic [2:0] VARIANT_6106 = 3'd3;

  localparam logic [31:0] SEED_6102    = 32'hF8CA_4DDC;
  localparam logic [31:0] SEED_6103    = 32'hA388_6759;
  localparam logic [31:0] SEED_6105    = 32'hDF26_F436;
  localparam logic [31:0] SEED_6106    = 32'h1FEA_617A;
  localparam logic [31:0] SEED_UNKNOWN = 32'h0000_0000;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_DATA = 1'b1
  } cic_kind_t;

  typedef struct packed {
    cic_kind_t             kind;
    logic [TABLE_AW-1:0]   table_index;
    logic [31:0]           data_word;
    logic [31:0]           rot_word;
    logic                  first_word;
    logic                  last_word;
  } cic_item_t;

  // rotate left by the low five bits, zero amount gives the word itself
  function automatic logic [31:0] rotl_low5(input logic [31:0] d);
    logic [63:0] t;
    t = {d, d} << d[4:0];
    return t[63:32];
  endfunction

  function automatic logic [31:0] seed_of(input logic [2:0] v);
    logic [31:0] s;
    unique case (v)
      VARIANT_6102: s = SEED_6102;
      VARIANT_6103: s = SEED_6103;
      VARIANT_6105: s = SEED_6105;
      VARIANT_6106: s = SEED_6106;
      default:      s = SEED_UNKNOWN;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/cic_ram.sv =====
// generic single write port ram with registered read
`default_nettype none

module cic_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/cic_queue.sv =====
// short word queue between the front and back parts
`default_nettype none

module cic_queue
  import cic_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire cic_item_t push_item,
  output logic           full,
  input  wire logic      pop,
  output logic           head_valid,
  output cic_item_t      head_item
);

  cic_item_t             slots [QUEUE_DEPTH];
  logic [QUEUE_PW-1:0]   wr_ptr;
  logic [QUEUE_PW-1:0]   rd_ptr;
  logic [QUEUE_CW-1:0]   count;

  assign full       = (count == QUEUE_CW'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/cic_front.sv =====
// input stage: takes words, classifies them and pre-rotates data words
`default_nettype none

module cic_front
  import cic_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                req_type,
  input  wire logic [TABLE_AW-1:0] table_index,
  input  wire logic [31:0]         data_word,
  input  wire logic                first_word,
  input  wire logic                last_word,
  input  wire logic                q_full,
  output logic                     push,
  output cic_item_t                push_item
);

  logic      held;
  cic_item_t item;
  cic_item_t item_next;
  logic      take;

  assign in_ready = !held || !q_full;
  assign take     = in_valid && in_ready;
  assign push     = held && !q_full;
  assign push_item = item;

  always_comb begin
    item_next.kind        = req_type ? KIND_DATA : KIND_LOAD;
    item_next.table_index = table_index;
    item_next.data_word   = data_word;
    item_next.rot_word    = rotl_low5(data_word);
    // markers only matter on data words
    item_next.first_word  = req_type && first_word;
    item_next.last_word   = req_type && last_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (take) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item <= item_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/cic_back.sv =====
// back part: boot table, accumulator update, checksum combine and output register
`default_nettype none

module cic_back
  import cic_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [2:0] variant,
  input  wire logic       head_valid,
  input  wire cic_item_t  head_item,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [31:0]     checksum_one,
  output logic [31:0]     checksum_two
);

  logic                adv;
  logic                is_data;
  logic [TABLE_AW-1:0] rd_pos;
  logic [TABLE_AW-1:0] wpos;
  logic [31:0]         tbl_word;

  // table read stage
  logic        a_valid;
  logic [31:0] a_d;
  logic [31:0] a_rot;
  logic        a_first;
  logic        a_last;

  // accumulators
  logic [31:0] acc_sum, acc_carry, acc_xor, acc_rsum, acc_cx, acc_mix;
  logic [31:0] base_sum, base_carry, base_xor, base_rsum, base_cx, base_mix;
  logic [31:0] sum_next, carry_next, xor_next, rsum_next, cx_next, mix_next;
  logic [31:0] mix_term;
  logic [32:0] sum_wide;
  logic [31:0] seed;
  logic        l_valid;

  // combine stage
  logic        p_valid;
  logic [31:0] p1, a1, p2, a2;
  logic [31:0] p1_next, a1_next, p2_next, a2_next;

  assign adv     = !out_valid || out_ready;
  assign pop     = head_valid && adv;
  assign is_data = (head_item.kind == KIND_DATA);
  assign rd_pos  = head_item.first_word ? '0 : wpos;

  cic_ram #(
    .WIDTH (32),
    .DEPTH (TABLE_WORDS)
  ) u_table (
    .clk   (clk),
    .we    (pop && !is_data),
    .waddr (head_item.table_index),
    .wdata (head_item.data_word),
    .re    (pop && is_data),
    .raddr (rd_pos),
    .rdata (tbl_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      wpos    <= '0;
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= pop && is_data;
      if (pop && is_data) begin
        wpos <= rd_pos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_d     <= head_item.data_word;
      a_rot   <= head_item.rot_word;
      a_first <= head_item.first_word;
      a_last  <= head_item.last_word;
    end
  end

  // per word update
  always_comb begin
    seed       = seed_of(variant);
    base_sum   = a_first ? seed : acc_sum;
    base_carry = a_first ? seed : acc_carry;
    base_xor   = a_first ? seed : acc_xor;
    base_rsum  = a_first ? seed : acc_rsum;
    base_cx    = a_first ? seed : acc_cx;
    base_mix   = a_first ? seed : acc_mix;

    sum_wide   = {1'b0, base_sum} + {1'b0, a_d};
    sum_next   = sum_wide[31:0];
    carry_next = base_carry + {31'd0, sum_wide[32]};
    xor_next   = base_xor ^ a_d;
    rsum_next  = base_rsum + a_rot;
    cx_next    = (base_cx > a_d) ? (base_cx ^ a_rot) : (base_cx ^ sum_next ^ a_d);
    mix_term   = (variant == VARIANT_6105) ? (tbl_word ^ a_d) : (rsum_next ^ a_d);
    mix_next   = base_mix + mix_term;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_sum   <= SEED_6102;
      acc_carry <= SEED_6102;
      acc_xor   <= SEED_6102;
      acc_rsum  <= SEED_6102;
      acc_cx    <= SEED_6102;
      acc_mix   <= SEED_6102;
      l_valid   <= 1'b0;
    end else if (adv) begin
      l_valid <= a_valid && a_last;
      if (a_valid) begin
        acc_sum   <= sum_next;
        acc_carry <= carry_next;
        acc_xor   <= xor_next;
        acc_rsum  <= rsum_next;
        acc_cx    <= cx_next;
        acc_mix   <= mix_next;
      end
    end
  end

  // checksum formula: product or xor term plus addend
  always_comb begin
    unique case (variant)
      VARIANT_6103: begin
        p1_next = acc_sum ^ acc_carry;
        a1_next = acc_xor;
        p2_next = acc_rsum ^ acc_cx;
        a2_next = acc_mix;
      end
      VARIANT_6106: begin
        p1_next = acc_sum * acc_carry;
        a1_next = acc_xor;
        p2_next = acc_rsum * acc_cx;
        a2_next = acc_mix;
      end
      default: begin
        p1_next = acc_sum ^ acc_carry ^ acc_xor;
        a1_next = '0;
        p2_next = acc_rsum ^ acc_cx ^ acc_mix;
        a2_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      p_valid   <= l_valid;
      out_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1           <= p1_next;
      a1           <= a1_next;
      p2           <= p2_next;
      a2           <= a2_next;
      checksum_one <= p1 + a1;
      checksum_two <= p2 + a2;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/cartridge_image_checksum.sv =====
// top level of the cartridge image checksum block
// path: front holding register, queue, table read, accumulators, combine stage, output register
// throughput: one word per cycle without output stalls, loads and data words alike; per-word
//   accumulator update is an add/xor chain, the boot table one ram with one write and one read port
// reset: synchronous; queue and pipeline emptied, accumulators seeded for 6102,
//   word position zero, variant register zero; the boot table is not cleared
// a stalled output register halts the back part; the queue lets the input run on until it fills
`default_nettype none

module cartridge_image_checksum
  import cic_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  // configuration write channel
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [2:0]          chip_variant,
  // input word channel
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                req_type,
  input  wire logic [TABLE_AW-1:0] table_index,
  input  wire logic [31:0]         data_word,
  input  wire logic                first_word,
  input  wire logic                last_word,
  // result word channel
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [31:0]              checksum_one,
  output logic [31:0]              checksum_two
);

  logic [2:0] variant;      // boot chip variant register
  logic       q_full;
  logic       push;
  cic_item_t  push_item;
  logic       pop;
  logic       head_valid;
  cic_item_t  head_item;

  // register writes are taken at any time
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      variant <= VARIANT_6102;
    end else if (cfg_valid && cfg_ready) begin
      variant <= chip_variant;
    end
  end

  // front: one holding stage, classifies the word and pre-computes its rotation
  cic_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .table_index (table_index),
    .data_word   (data_word),
    .first_word  (first_word),
    .last_word   (last_word),
    .q_full      (q_full),
    .push        (push),
    .push_item   (push_item)
  );

  // decoupling queue
  cic_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  // back: table load/read, accumulators, checksum combine, output register
  cic_back u_back (
    .clk          (clk),
    .rst          (rst),
    .variant      (variant),
    .head_valid   (head_valid),
    .head_item    (head_item),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .checksum_one (checksum_one),
    .checksum_two (checksum_two)
  );

endmodule

`default_nettype wire

// ===== hdl/cic_checker.sv =====
// port-level checker for the cartridge image checksum and its bind
`default_nettype none

module cic_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] checksum_one,
  input wire logic [31:0] checksum_two
);

  // input side is open right after reset
  a_ready_after_reset: assert property (@(posedge clk) rst |=> in_ready)
    else $error("in_ready low after reset");

  // no result word right after reset
  a_no_result_after_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  // a stalled result word holds
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(checksum_one) && $stable(checksum_two))
    else $error("stalled result word changed");

endmodule

bind cartridge_image_checksum cic_checker u_cic_checker (.*);

`default_nettype wire
